// ===== hdl/cabf_pkg.sv =====
`default_nettype none
package cabf_pkg;

	localparam int FRAME_WIDTH  = 256;
	localparam int FRAME_HEIGHT = 64;
	localparam int STORE_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int QUEUE_DEPTH  = 2;
	localparam logic [31:0] BLEND_COLOUR_RESET = 32'hFF00_0000;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BLEND = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t              op;
		logic              in_frame;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        cov;
		logic [31:0]       art;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_SA_MUL,
		ST_SA_DIV,
		ST_DW_MUL,
		ST_DW_DIV,
		ST_CH_MUL,
		ST_CH_ADD,
		ST_CH_DIV,
		ST_FINISH
	} state_t;

	function automatic logic [7:0] div255(input logic [16:0] v);
		logic [16:0] t;
		t = v + (v >> 8) + 17'd1;
		return t[15:8];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/cabf_front.sv =====
`default_nettype none
module cabf_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           cmd,
	input  wire logic signed [10:0]   x_pos,
	input  wire logic signed [10:0]   y_pos,
	input  wire logic [7:0]           coverage,
	input  wire logic [7:0]           red_byte,
	input  wire logic [7:0]           green_byte,
	input  wire logic [7:0]           blue_byte,
	input  wire logic [7:0]           alpha_byte,
	output cabf_pkg::queue_head_t     head,
	input  wire logic                 pop
);

	cabf_pkg::item_t q_mem_q [cabf_pkg::QUEUE_DEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	cabf_pkg::item_t item_c;
	logic            push;
	logic            x_ok;
	logic            y_ok;

	assign x_ok = !x_pos[10] && (12'({1'b0, x_pos[9:0]}) < 12'(cabf_pkg::FRAME_WIDTH));
	assign y_ok = !y_pos[10] && (12'({1'b0, y_pos[9:0]}) < 12'(cabf_pkg::FRAME_HEIGHT));

	always_comb begin
		item_c.op       = cabf_pkg::cmd_t'(cmd);
		item_c.in_frame = x_ok && y_ok;
		item_c.addr     = cabf_pkg::ADDR_W'(21'(y_pos[9:0]) * 21'(cabf_pkg::FRAME_WIDTH)
		                  + 21'(x_pos[9:0]));
		item_c.cov      = coverage;
		item_c.art      = {alpha_byte, blue_byte, green_byte, red_byte};
	end

	assign in_stall   = (count_q == 2'(cabf_pkg::QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head.valid = (count_q != 2'd0);
	assign head.item  = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cabf_back.sv =====
`default_nettype none
module cabf_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [31:0]          colour,
	input  wire cabf_pkg::queue_head_t head,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [31:0]               pixel_word,
	output logic                      in_frame
);

	logic [31:0]      mem [cabf_pkg::STORE_DEPTH];
	cabf_pkg::state_t state_q;
	cabf_pkg::state_t state_d;
	cabf_pkg::item_t  item_q;
	logic [31:0]      rdata_q;
	logic [31:0]      res_q;
	logic             wr_q;
	logic [16:0]      prod_q;
	logic [7:0]       sa_q;
	logic [7:0]       dw_q;
	logic [16:0]      num_q;
	logic [8:0]       rem_q;
	logic [4:0]       cnt_q;
	logic [1:0]       ch_q;
	logic             out_valid_q;
	logic [31:0]      pixel_q;
	logic             in_frame_q;
	logic [8:0]       oa;
	logic [9:0]       trial;
	logic             fits;
	logic [7:0]       src_b;
	logic [7:0]       dst_b;
	logic [7:0]       sa_c;
	logic             out_free;

	assign oa       = 9'(sa_q) + 9'(dw_q);
	assign trial    = {rem_q, num_q[16]};
	assign fits     = (trial >= {1'b0, oa});
	assign sa_c     = cabf_pkg::div255(prod_q);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		case (ch_q)
			2'd0: begin
				src_b = colour[7:0];
				dst_b = rdata_q[7:0];
			end
			2'd1: begin
				src_b = colour[15:8];
				dst_b = rdata_q[15:8];
			end
			default: begin
				src_b = colour[23:16];
				dst_b = rdata_q[23:16];
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			cabf_pkg::ST_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					state_d = cabf_pkg::ST_READ;
				end
			end
			cabf_pkg::ST_READ: state_d = cabf_pkg::ST_EXEC;
			cabf_pkg::ST_EXEC: begin
				if (item_q.in_frame && item_q.op == cabf_pkg::CMD_BLEND && item_q.cov != 8'd0) begin
					state_d = cabf_pkg::ST_SA_MUL;
				end else begin
					state_d = cabf_pkg::ST_FINISH;
				end
			end
			cabf_pkg::ST_SA_MUL: state_d = cabf_pkg::ST_SA_DIV;
			cabf_pkg::ST_SA_DIV: begin
				state_d = (sa_c == 8'd0) ? cabf_pkg::ST_FINISH : cabf_pkg::ST_DW_MUL;
			end
			cabf_pkg::ST_DW_MUL: state_d = cabf_pkg::ST_DW_DIV;
			cabf_pkg::ST_DW_DIV: state_d = cabf_pkg::ST_CH_MUL;
			cabf_pkg::ST_CH_MUL: state_d = cabf_pkg::ST_CH_ADD;
			cabf_pkg::ST_CH_ADD: state_d = cabf_pkg::ST_CH_DIV;
			cabf_pkg::ST_CH_DIV: begin
				if (cnt_q == 5'd17) begin
					state_d = (ch_q == 2'd2) ? cabf_pkg::ST_FINISH : cabf_pkg::ST_CH_MUL;
				end
			end
			cabf_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = cabf_pkg::ST_IDLE;
				end
			end
			default: state_d = cabf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cabf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cabf_pkg::ST_FINISH && wr_q) begin
			mem[item_q.addr] <= res_q;
		end
		if (state_q == cabf_pkg::ST_READ) begin
			rdata_q <= mem[item_q.addr];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cabf_pkg::ST_IDLE: begin
				if (head.valid) begin
					item_q <= head.item;
				end
			end
			cabf_pkg::ST_EXEC: begin
				wr_q <= 1'b0;
				if (!item_q.in_frame) begin
					res_q <= 32'd0;
				end else if (item_q.op == cabf_pkg::CMD_LOAD) begin
					res_q <= item_q.art;
					wr_q  <= 1'b1;
				end else begin
					res_q <= rdata_q;
				end
			end
			cabf_pkg::ST_SA_MUL: prod_q <= 17'(colour[31:24]) * 17'(item_q.cov);
			cabf_pkg::ST_SA_DIV: sa_q <= sa_c;
			cabf_pkg::ST_DW_MUL: begin
				prod_q <= 17'(rdata_q[31:24]) * 17'(8'd255 - sa_q) + 17'd127;
			end
			cabf_pkg::ST_DW_DIV: begin
				dw_q <= sa_c;
				ch_q <= 2'd0;
			end
			cabf_pkg::ST_CH_MUL: num_q <= 17'(src_b) * 17'(sa_q);
			cabf_pkg::ST_CH_ADD: begin
				num_q <= num_q + 17'(dst_b) * 17'(dw_q) + 17'(oa >> 1);
				rem_q <= 9'd0;
				cnt_q <= 5'd0;
			end
			cabf_pkg::ST_CH_DIV: begin
				if (cnt_q == 5'd17) begin
					case (ch_q)
						2'd0: res_q[7:0] <= num_q[7:0];
						2'd1: res_q[15:8] <= num_q[7:0];
						default: begin
							res_q[23:16] <= num_q[7:0];
							res_q[31:24] <= oa[7:0];
							wr_q         <= 1'b1;
						end
					endcase
					ch_q <= ch_q + 2'd1;
				end else begin
					rem_q <= fits ? 9'(trial - {1'b0, oa}) : trial[8:0];
					num_q <= {num_q[15:0], fits};
					cnt_q <= cnt_q + 5'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == cabf_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cabf_pkg::ST_FINISH && out_free) begin
			pixel_q    <= res_q;
			in_frame_q <= item_q.in_frame;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_word = pixel_q;
	assign in_frame   = in_frame_q;

endmodule
`default_nettype wire

// ===== hdl/coverage_alpha_blend_framebuffer_core.sv =====
// ARGB frame store with coverage blending. Items are classified on entry
// (in-frame test, row-major address) and wait in a two-entry queue; the back
// end executes one item at a time against a single-port pixel memory. Load,
// read, off-frame and zero-coverage items skip the blend steps in the back
// end; a blend whose scaled alpha is zero stops after the alpha scaling; a
// full blend runs the bit-serial restoring divider that produces each of the
// three colour channels in 17 steps plus a write-back step. blend_colour
// must only be written while no item is in flight. Pixels must be loaded
// before they are read or blended.
`default_nettype none
module coverage_alpha_blend_framebuffer_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               blend_colour_we,
	input  wire logic [31:0]        blend_colour,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [10:0] x_pos,
	input  wire logic signed [10:0] y_pos,
	input  wire logic [7:0]         coverage,
	input  wire logic [7:0]         red_byte,
	input  wire logic [7:0]         green_byte,
	input  wire logic [7:0]         blue_byte,
	input  wire logic [7:0]         alpha_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [31:0]             pixel_word,
	output logic                    in_frame
);

	logic [31:0]           colour_q;
	cabf_pkg::queue_head_t head;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q <= cabf_pkg::BLEND_COLOUR_RESET;
		end else if (blend_colour_we) begin
			colour_q <= blend_colour;
		end
	end

	cabf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.coverage   (coverage),
		.red_byte   (red_byte),
		.green_byte (green_byte),
		.blue_byte  (blue_byte),
		.alpha_byte (alpha_byte),
		.head       (head),
		.pop        (pop)
	);

	cabf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.colour     (colour_q),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_word (pixel_word),
		.in_frame   (in_frame)
	);

endmodule
`default_nettype wire

// ===== hdl/cabf_checker.sv =====
`default_nettype none
module cabf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [31:0]        pixel_word,
	input wire logic               in_frame
);

	logic [7:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 8'd0;
		end else begin
			pend_q <= pend_q + 8'(in_valid && !in_stall) - 8'(out_valid && !out_stall);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_word) && $stable(in_frame))
		else $error("result changed while stalled");

	a_off_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_frame |-> pixel_word == 32'd0)
		else $error("off-frame result is not zero");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 8'd0)
		else $error("result without a pending transfer");

endmodule

bind coverage_alpha_blend_framebuffer_core cabf_checker u_cabf_checker (.*);
`default_nettype wire
